>>> hdl/tctt_pkg.sv
// tctt_pkg: shared types, codes and helpers for the connection timer table
// used by tctt_ctrl, tctt_dpath and tcp_connection_timer_table_unit
// no dependencies
package tctt_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int STEP_W = SLOT_W + 1;

	localparam int TICK_W  = 20;
	localparam int TW_W    = 31;
	localparam int RTI_W   = 24;
	localparam int RETRY_W = 4;
	localparam int LEFT_W  = 32;
	localparam int CFG_W   = 31;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEFT_W-1:0] MAX_LEFT = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_ARM_TW     = 3'd1,
		MODE_ARM_RT     = 3'd2,
		MODE_DISARM_RT  = 3'd3,
		MODE_RESTART_RT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		EV_RELEASE    = 2'd0,
		EV_RETRANSMIT = 2'd1,
		EV_ABORT      = 2'd2
	} ev_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_STEP   = 2'd0,
		CFG_TW_LENGTH   = 2'd1,
		CFG_RT_INITIAL  = 2'd2,
		CFG_RETRY_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] slot;
		logic       send_queue_empty;
	} in_item_t;

	typedef struct packed {
		logic [3:0] event_slot;
		logic [1:0] event_kind;
		logic       last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic do_cmd;
		logic do_step;
		logic do_flush;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic step_ok;
		logic last_step;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	function automatic logic expired(input logic [LEFT_W-1:0] v);
		return (v == '0) || v[LEFT_W-1];
	endfunction

	// initial interval shifted by the retry count, saturating
	function automatic logic [LEFT_W-1:0] backoff(input logic [RTI_W-1:0] init,
			input logic [RETRY_W-1:0] cnt);
		logic [RTI_W+14:0] sh;
		sh = {15'd0, init} << cnt;
		if (|sh[RTI_W+14:LEFT_W-1])
			return MAX_LEFT;
		return {1'b0, sh[LEFT_W-2:0]};
	endfunction

endpackage

>>> hdl/tctt_ctrl.sv
// tctt_ctrl: sequencer for the connection timer table
// decides between commands, the tick walk and the final flush; uses tctt_pkg
module tctt_ctrl import tctt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_mode,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_mode == MODE_TICK)
						state_d = ST_WALK;
					else
						cmd.do_cmd = 1'b1;
				end
			end
			ST_WALK: begin
				cmd.do_step = 1'b1;
				if (status.step_ok && status.last_step)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.do_flush = 1'b1;
				if (!status.pend_valid || status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_walk_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_d == ST_WALK) |-> (in_valid && in_mode == MODE_TICK))
		else $error("walk started without a tick");

	a_flush_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && status.step_ok && status.last_step) |=> state_q == ST_FLUSH)
		else $error("walk end did not lead to flush");
`endif

endmodule

>>> hdl/tctt_dpath.sv
// tctt_dpath: timer storage, per-timer update, event hold and output register
// driven by tctt_ctrl commands; uses tctt_pkg
module tctt_dpath import tctt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  in_item_t             in_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	// configuration
	logic [TICK_W-1:0]  tick_step_q;
	logic [TW_W-1:0]    tw_length_q;
	logic [RTI_W-1:0]   rt_initial_q;
	logic [RETRY_W-1:0] retry_limit_q;

	// timer table
	logic [SLOTS-1:0]   tw_armed_q;
	logic [SLOTS-1:0]   rt_armed_q;
	logic [LEFT_W-1:0]  tw_left_q [SLOTS];
	logic [LEFT_W-1:0]  rt_left_q [SLOTS];
	logic [RETRY_W-1:0] retry_q   [SLOTS];

	// walk position: upper bits slot, low bit selects the retransmit timer
	logic [STEP_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  wslot;
	logic               is_rt;

	logic               pend_valid_q;
	logic [3:0]         pend_slot_q;
	logic [1:0]         pend_kind_q;

	logic               out_valid_q;
	out_item_t          out_item_q;

	logic [LEFT_W-1:0]  tw_sub, rt_sub, rt_reload;
	logic               tw_fire, rt_fire, at_limit;
	logic               ev_found;
	logic [1:0]         ev_kind;
	logic               step_ok, out_free, advance, push_mid, push_last;
	logic [SLOT_W-1:0]  cslot;

	assign wslot = idx_q[STEP_W-1:1];
	assign is_rt = idx_q[0];
	assign cslot = in_item.slot[SLOT_W-1:0];

	assign tw_sub    = tw_left_q[wslot] - {{(LEFT_W-TICK_W){1'b0}}, tick_step_q};
	assign rt_sub    = rt_left_q[wslot] - {{(LEFT_W-TICK_W){1'b0}}, tick_step_q};
	assign tw_fire   = tw_armed_q[wslot] && expired(tw_sub);
	assign rt_fire   = rt_armed_q[wslot] && expired(rt_sub);
	assign at_limit  = retry_q[wslot] >= retry_limit_q;
	assign rt_reload = backoff(rt_initial_q, retry_q[wslot] + 1'b1);

	always_comb begin
		if (is_rt) begin
			ev_found = rt_fire;
			ev_kind  = at_limit ? EV_ABORT : EV_RETRANSMIT;
		end else begin
			ev_found = tw_fire;
			ev_kind  = EV_RELEASE;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign step_ok   = !(ev_found && pend_valid_q) || out_free;
	assign advance   = cmd.do_step && step_ok;
	assign push_mid  = advance && ev_found && pend_valid_q;
	assign push_last = cmd.do_flush && pend_valid_q && out_free;

	assign status.step_ok    = step_ok;
	assign status.last_step  = &idx_q;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q   <= TICK_W'(100000);
			tw_length_q   <= TW_W'(4000000);
			rt_initial_q  <= RTI_W'(200000);
			retry_limit_q <= RETRY_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICK_STEP:   tick_step_q   <= cfg_data[TICK_W-1:0];
				CFG_TW_LENGTH:   tw_length_q   <= cfg_data[TW_W-1:0];
				CFG_RT_INITIAL:  rt_initial_q  <= cfg_data[RTI_W-1:0];
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// armed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_armed_q <= '0;
			rt_armed_q <= '0;
		end else if (cmd.do_cmd) begin
			case (in_item.mode)
				MODE_ARM_TW:     tw_armed_q[cslot] <= 1'b1;
				MODE_ARM_RT:     rt_armed_q[cslot] <= 1'b1;
				MODE_DISARM_RT:  rt_armed_q[cslot] <= 1'b0;
				MODE_RESTART_RT: rt_armed_q[cslot] <= !in_item.send_queue_empty;
				default: ;
			endcase
		end else if (advance) begin
			if (!is_rt && tw_fire)
				tw_armed_q[wslot] <= 1'b0;
			if (is_rt && rt_fire && at_limit)
				rt_armed_q[wslot] <= 1'b0;
		end
	end

	// timer values and retry counts
	always_ff @(posedge clk) begin
		if (cmd.do_cmd) begin
			case (in_item.mode)
				MODE_ARM_TW: tw_left_q[cslot] <= {1'b0, tw_length_q};
				MODE_ARM_RT: begin
					rt_left_q[cslot] <= {{(LEFT_W-RTI_W){1'b0}}, rt_initial_q};
					retry_q[cslot]   <= '0;
				end
				MODE_RESTART_RT: begin
					if (!in_item.send_queue_empty) begin
						rt_left_q[cslot] <= {{(LEFT_W-RTI_W){1'b0}}, rt_initial_q};
						retry_q[cslot]   <= '0;
					end
				end
				default: ;
			endcase
		end else if (advance) begin
			if (!is_rt && tw_armed_q[wslot])
				tw_left_q[wslot] <= tw_sub;
			if (is_rt && rt_armed_q[wslot]) begin
				if (rt_fire && !at_limit) begin
					rt_left_q[wslot] <= rt_reload;
					retry_q[wslot]   <= retry_q[wslot] + 1'b1;
				end else begin
					rt_left_q[wslot] <= rt_sub;
				end
			end
		end
	end

	// walk index, held event and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (!cmd.do_step)
				idx_q <= '0;
			else if (advance)
				idx_q <= idx_q + 1'b1;

			// one event is held back so the final one of a tick can carry last
			if (advance && ev_found)
				pend_valid_q <= 1'b1;
			else if (push_last)
				pend_valid_q <= 1'b0;

			if (push_mid || push_last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_found) begin
			pend_slot_q <= 4'(wslot);
			pend_kind_q <= ev_kind;
		end
		if (push_mid || push_last) begin
			out_item_q.event_slot <= pend_slot_q;
			out_item_q.event_kind <= pend_kind_q;
			out_item_q.last       <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.event_kind == EV_RELEASE ||
			out_item_q.event_kind == EV_RETRANSMIT || out_item_q.event_kind == EV_ABORT))
		else $error("illegal event kind on output");

	a_pend_after_event: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ev_found) |=> pend_valid_q)
		else $error("found event was not held");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push_last |=> (!pend_valid_q && out_valid_q && out_item_q.last))
		else $error("flush did not deliver the held event as last");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.do_step |=> idx_q == '0)
		else $error("walk index not cleared outside a walk");
`endif

endmodule

>>> hdl/tcp_connection_timer_table_unit.sv
// Connection timer table: 16 slots, each with a time-wait timer and a
// retransmission timer with exponential backoff.
// Input channel (in_valid/in_stall, in_item): one command or tick per item.
//   Commands (arm time-wait, arm, disarm or restart retransmit) give no
//   output. A tick walks every slot's two timers, one timer per cycle
//   while the walk is not paused, then hands the final event to the output
//   register; the input stalls from the tick being taken until that is done.
// Output channel (out_valid/out_stall, out_item): one item per expired timer,
//   in slot order, time-wait before retransmit for one slot; last marks the
//   final event of the tick. Events leave through one output register, and
//   one found event is held back until the next is found or the walk ends.
//   The walk pauses at a found event while one is held and out_stall blocks.
// Configuration (cfg_we, cfg_index, cfg_data) writes a register;
//   write only while no tick is in progress.
// Reset (arst_n, async, active low) disarms all timers and restores the
//   default register values; timer values are loaded whenever armed.
module tcp_connection_timer_table_unit import tctt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	tctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_item.mode),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tctt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

>>> test/tcp_connection_timer_table_unit_tb.sv
// tcp_connection_timer_table_unit_tb: directed and random test of the connection timer table
// keeps its own model of both timers per slot and checks every event item in order
// depends on tctt_pkg and tcp_connection_timer_table_unit
`timescale 1ns / 1ps

module tcp_connection_timer_table_unit_tb;
	import tctt_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tcp_connection_timer_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies
	logic [TICK_W-1:0]  step_reg   = 20'd100000;
	logic [TW_W-1:0]    tw_len_reg = 31'd4000000;
	logic [RTI_W-1:0]   rt_init_reg = 24'd200000;
	logic [RETRY_W-1:0] retry_lim_reg = 4'd3;

	// timer table copy
	logic              tw_on    [SLOTS];
	logic [LEFT_W-1:0] tw_left  [SLOTS];
	logic              rt_on    [SLOTS];
	logic [LEFT_W-1:0] rt_left  [SLOTS];
	logic [RETRY_W-1:0] retries [SLOTS];

	out_item_t expected_events[$];

	int items_sent;
	int ticks_sent;
	int events_seen;
	int mismatches;
	bit no_gaps;

	always #10 clk = ~clk;

	function automatic logic timer_due(input logic [LEFT_W-1:0] v);
		return (v == '0) || v[LEFT_W-1];
	endfunction

	function automatic logic [LEFT_W-1:0] backed_off(input logic [RETRY_W-1:0] n);
		logic [55:0] wide;
		wide = {32'd0, rt_init_reg} << n;
		if (wide > 56'h7FFF_FFFF)
			return MAX_LEFT;
		return wide[LEFT_W-1:0];
	endfunction

	task automatic predict_events(input in_item_t it);
		out_item_t batch[$];
		out_item_t ev;
		case (it.mode)
			MODE_TICK: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (tw_on[s]) begin
						tw_left[s] = tw_left[s] - LEFT_W'(step_reg);
						if (timer_due(tw_left[s])) begin
							tw_on[s] = 1'b0;
							ev.event_slot = s[3:0];
							ev.event_kind = EV_RELEASE;
							ev.last = 1'b0;
							batch.push_back(ev);
						end
					end
					if (rt_on[s]) begin
						rt_left[s] = rt_left[s] - LEFT_W'(step_reg);
						if (timer_due(rt_left[s])) begin
							ev.event_slot = s[3:0];
							ev.last = 1'b0;
							if (retries[s] >= retry_lim_reg) begin
								rt_on[s] = 1'b0;
								ev.event_kind = EV_ABORT;
							end else begin
								retries[s] = retries[s] + 4'd1;
								rt_left[s] = backed_off(retries[s]);
								ev.event_kind = EV_RETRANSMIT;
							end
							batch.push_back(ev);
						end
					end
				end
				for (int i = 0; i < batch.size(); i++) begin
					ev = batch[i];
					ev.last = (i == batch.size() - 1);
					expected_events.push_back(ev);
				end
			end
			MODE_ARM_TW: begin
				tw_on[it.slot] = 1'b1;
				tw_left[it.slot] = {1'b0, tw_len_reg};
			end
			MODE_ARM_RT: begin
				rt_on[it.slot] = 1'b1;
				rt_left[it.slot] = {8'd0, rt_init_reg};
				retries[it.slot] = '0;
			end
			MODE_DISARM_RT: rt_on[it.slot] = 1'b0;
			MODE_RESTART_RT: begin
				if (it.send_queue_empty) begin
					rt_on[it.slot] = 1'b0;
				end else begin
					rt_on[it.slot] = 1'b1;
					rt_left[it.slot] = {8'd0, rt_init_reg};
					retries[it.slot] = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input mode_t m, input logic [3:0] s, input logic sqe);
		in_item_t it;
		int gap;
		bit taken;
		it.mode = m;
		it.slot = s;
		it.send_queue_empty = sqe;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		// predicted now, ahead of any event this tick can cause
		predict_events(it);
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		items_sent++;
		if (m == MODE_TICK)
			ticks_sent++;
	endtask

	// drain all events, then let a tick with no events finish its walk
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
	endtask

	task automatic load_regs(input logic [TICK_W-1:0] step, input logic [TW_W-1:0] tw,
			input logic [RTI_W-1:0] rt, input logic [RETRY_W-1:0] lim);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICK_STEP;
		cfg_data <= CFG_W'(step);
		@(posedge clk);
		cfg_index <= CFG_TW_LENGTH;
		cfg_data <= CFG_W'(tw);
		@(posedge clk);
		cfg_index <= CFG_RT_INITIAL;
		cfg_data <= CFG_W'(rt);
		@(posedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= CFG_W'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
		step_reg = step;
		tw_len_reg = tw;
		rt_init_reg = rt;
		retry_lim_reg = lim;
	endtask

	task automatic note_mismatch(input string why, input out_item_t want, input out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected slot %0d kind %0d last %0d, %s",
				why, want.event_slot, want.event_kind, want.last,
				$sformatf("got slot %0d kind %0d last %0d",
					got.event_slot, got.event_kind, got.last));
	endtask

	task automatic check_event(input out_item_t got);
		out_item_t want;
		events_seen++;
		if (expected_events.size() == 0) begin
			note_mismatch("no event pending", '0, got);
		end else begin
			want = expected_events.pop_front();
			if (got.event_slot !== want.event_slot || got.event_kind !== want.event_kind ||
					got.last !== want.last)
				note_mismatch("field", want, got);
		end
	endtask

	// default registers: a tick with nothing due, then a first retransmit
	task automatic test_default_regs();
		send_item(MODE_ARM_RT, 4'd15, 1'b0);
		send_item(MODE_TICK, 4'd0, 1'b0);
		send_item(MODE_TICK, 4'd5, 1'b1);
	endtask

	// every command, both timers of a slot at once, rearm, disarm of idle timers
	task automatic test_command_mix();
		load_regs(20'd1000000, 31'd1, 24'd1, 4'd0);
		send_item(MODE_ARM_TW, 4'd3, 1'b0);
		send_item(MODE_ARM_RT, 4'd3, 1'b1);
		send_item(MODE_ARM_RT, 4'd0, 1'b0);
		send_item(MODE_DISARM_RT, 4'd0, 1'b0);
		send_item(MODE_RESTART_RT, 4'd7, 1'b1);
		send_item(MODE_RESTART_RT, 4'd9, 1'b0);
		send_item(MODE_ARM_RT, 4'd9, 1'b0);
		send_item(MODE_DISARM_RT, 4'd12, 1'b1);
		send_item(MODE_TICK, 4'd15, 1'b0);
	endtask

	// climb the retry count, then raise the initial interval so the reload saturates
	task automatic test_backoff_saturation();
		load_regs(20'd1000000, 31'h7FFF_FFFF, 24'd1, 4'd15);
		send_item(MODE_ARM_RT, 4'd10, 1'b0);
		repeat (7) send_item(MODE_TICK, 4'd0, 1'b0);
		load_regs(20'd1000000, 31'h7FFF_FFFF, 24'hFF_FFFF, 4'd15);
		send_item(MODE_ARM_TW, 4'd12, 1'b0);
		send_item(MODE_TICK, 4'd0, 1'b0);
		send_item(MODE_TICK, 4'd0, 1'b0);
	endtask

	task automatic test_random_traffic();
		longint step, tw, rt;
		int lim, pick;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: begin
					step = 1;
					tw = $urandom_range(1, 4);
					rt = $urandom_range(1, 3);
				end
				2: begin
					step = 1000000;
					tw = 64'h7FFF_FFFF;
					rt = $urandom_range(1, 3000000);
				end
				default: begin
					step = $urandom_range(1000, 1000000);
					tw = step * $urandom_range(1, 6) - $urandom_range(0, step - 1);
					rt = step * $urandom_range(1, 3) - $urandom_range(0, step - 1);
				end
			endcase
			lim = (phase == 2) ? 15 : $urandom_range(0, 15);
			load_regs(step[19:0], tw[30:0], rt[23:0], lim[3:0]);
			for (int i = 0; i < 50; i++) begin
				no_gaps = (i >= 20 && i < 30);
				if (i == 35)
					wait_idle();
				pick = $urandom_range(0, 9);
				if (pick <= 2)
					send_item(MODE_TICK, 4'($urandom_range(0, 15)), 1'($urandom));
				else if (pick <= 4)
					send_item(MODE_ARM_TW, 4'($urandom_range(0, 15)), 1'($urandom));
				else if (pick <= 6)
					send_item(MODE_ARM_RT, 4'($urandom_range(0, 15)), 1'($urandom));
				else if (pick == 7)
					send_item(MODE_DISARM_RT, 4'($urandom_range(0, 15)), 1'($urandom));
				else
					send_item(MODE_RESTART_RT, 4'($urandom_range(0, 15)), 1'($urandom));
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin : event_checker
		int hold;
		bit taken;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = no_gaps ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = out_valid;
				if (taken)
					check_event(out_item);
				@(posedge clk);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TICK_STEP;
		cfg_data = '0;
		no_gaps = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			tw_on[s] = 1'b0;
			rt_on[s] = 1'b0;
			tw_left[s] = '0;
			rt_left[s] = '0;
			retries[s] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_regs();
		test_command_mix();
		test_backoff_saturation();
		test_random_traffic();
		wait_idle();

		$display("sent %0d items (%0d ticks) and checked %0d events", items_sent, ticks_sent,
			events_seen);
		$display("register settings: defaults, extremes and random; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
